// ----- design/pgw_pkg.sv -----
// ----------------------------------------------------------------------------
// pgw_pkg
// Shared types, codes and helpers for the four-level page table walker.
// ----------------------------------------------------------------------------
package pgw_pkg;

  localparam int PA_W     = 52;
  localparam int VA_W     = 48;
  localparam int ENTRY_W  = 64;
  localparam int LVL_W    = 3;
  localparam int IDX_W    = 9;
  localparam int PHYS_ADDR_BITS_DEF = 52;

  localparam int SHIFT_1G = 30;
  localparam int SHIFT_2M = 21;
  localparam int SHIFT_4K = 12;

  // bit positions in a table entry
  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  typedef enum logic {
    OP_START = 1'b0,
    OP_ENTRY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_REQ   = 2'd0,
    ST_DONE  = 2'd1,
    ST_FAULT = 2'd2,
    ST_UNEXP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K = 2'd0,
    SZ_2M = 2'd1,
    SZ_1G = 2'd2
  } size_t;

  localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_1    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 3'd2;
  localparam logic [LVL_W-1:0] LVL_3    = 3'd3;
  localparam logic [LVL_W-1:0] LVL_4    = 3'd4;

  typedef struct packed {
    op_t                operation;
    logic [PA_W-1:0]    root_address;
    logic [VA_W-1:0]    virtual_address;
    logic [ENTRY_W-1:0] entry_data;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [PA_W-1:0]  address;
    size_t            page_size;
    logic [LVL_W-1:0] level;
  } result_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [VA_W-1:0]  va;
  } walk_state_t;

  // frame bits: 12 up to the implemented physical width
  function automatic logic [PA_W-1:0] frame_mask(int unsigned bits);
    logic [PA_W-1:0] m;
    for (int i = 0; i < PA_W; i++) begin
      m[i] = (i >= SHIFT_4K) && (i < bits);
    end
    return m;
  endfunction

  // nine-bit table index for a level
  function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va,
                                                   logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_4:   idx = va[47:39];
      LVL_3:   idx = va[38:30];
      LVL_2:   idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // table base is 4 KB aligned, so base plus index times eight is an or
  function automatic logic [PA_W-1:0] entry_addr(logic [PA_W-1:0] base,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [PA_W-1:0] mask);
    return (base & mask) | PA_W'({idx, 3'b000});
  endfunction

endpackage

// ----- design/four_level_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// x86-64 four-level page table walk, one table level per request: a start
// yields the level-4 entry read, a returned entry the next read, a finished
// translation, a not-present fault, or, with no walk pending, ST_UNEXP.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ----------------------------------------------
//  in       in_valid / in_stall  operation, root_address, virtual_address,
//                                entry_data
//  out      out_valid/out_stall  status, result_address, page_size, walk_level
//
//  one request per cycle unless the result side stalls; a request goes through
//  the input register, one level of step logic, then the result register
//  walk state moves as a request leaves the input register, so back to back
//  entries see the level left by the request just before
//  reset clears the valid flags and the walk state to idle; no clearing pass
//  a stalled result freezes full registers; in_stall rises only when both are full
//
module four_level_page_table_walker
  import pgw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [PA_W-1:0]    root_address,
  input  logic [VA_W-1:0]    virtual_address,
  input  logic [ENTRY_W-1:0] entry_data,
  // result side
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [PA_W-1:0]    result_address,
  output logic [1:0]         page_size,
  output logic [LVL_W-1:0]   walk_level
);

  item_t       in_item;
  item_t       held_item;
  logic        held_valid;
  logic        advance;
  logic        out_room;
  result_t     step_res;
  result_t     out_res;
  walk_state_t walk;
  walk_state_t walk_next;

  // pending level and latched virtual address
  logic [LVL_W-1:0] pending_level;
  logic [VA_W-1:0]  held_address;

  assign in_item.operation       = op_t'(operation);
  assign in_item.root_address    = root_address;
  assign in_item.virtual_address = virtual_address;
  assign in_item.entry_data      = entry_data;

  // result register has room when empty or being drained this cycle
  assign out_room = !out_valid || !out_stall;

  pgw_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance_ok (out_room),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  assign walk.level = pending_level;
  assign walk.va    = held_address;

  pgw_step #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_step (
    .item (held_item),
    .cur  (walk),
    .res  (step_res),
    .nxt  (walk_next)
  );

  // walk state moves with each request that reaches the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_level <= LVL_IDLE;
      held_address  <= '0;
    end else if (advance) begin
      pending_level <= walk_next.level;
      held_address  <= walk_next.va;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign status         = out_res.status;
  assign result_address = out_res.address;
  assign page_size      = out_res.page_size;
  assign walk_level     = out_res.level;

  // walk level never leaves the idle to top range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    pending_level <= LVL_4)
    else $error("pending level out of range");

  // a start always leaves a level-4 walk pending
  a_start_level: assert property (@(posedge clk) disable iff (rst)
    advance && held_item.operation == OP_START |=> pending_level == LVL_4)
    else $error("start did not arm a level-4 walk");

  // the input side stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // stray entry gives an all-zero result
  a_unexp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNEXP |-> result_address == '0 && walk_level == LVL_IDLE)
    else $error("unexpected-item result not cleared");

  // read requests are eight-byte aligned and name a real level
  a_req_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REQ |-> result_address[2:0] == 3'b000
      && walk_level != LVL_IDLE && page_size == SZ_4K)
    else $error("malformed entry read request");

endmodule

// ----- design/pgw_in_stage.sv -----
// ----------------------------------------------------------------------------
// pgw_in_stage
// Input register of the walker: holds one request until the step logic and
// result register can take it.
// ----------------------------------------------------------------------------
module pgw_in_stage
  import pgw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance_ok,
  output logic  held_valid,
  output item_t held_item,
  output logic  advance
);

  // moves into the step logic when the result register has room
  assign advance  = held_valid && advance_ok;
  assign in_stall = held_valid && !advance_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- design/pgw_step.sv -----
// ----------------------------------------------------------------------------
// pgw_step
// One level of the walk: checks an entry or starts a walk, forms the next
// entry address or the final physical address, and the next walk state.
// ----------------------------------------------------------------------------
module pgw_step
  import pgw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
  input  item_t       item,
  input  walk_state_t cur,
  output result_t     res,
  output walk_state_t nxt
);

  localparam logic [PA_W-1:0] FRAME_MASK = frame_mask(PHYS_ADDR_BITS);

  logic [PA_W-1:0] e_pa;
  logic            present;
  logic            large_pg;

  assign e_pa     = item.entry_data[PA_W-1:0];
  assign present  = item.entry_data[PRESENT_BIT];
  assign large_pg = item.entry_data[LARGE_BIT];

  always_comb begin
    nxt           = cur;
    res.status    = ST_UNEXP;
    res.address   = '0;
    res.page_size = SZ_4K;
    res.level     = LVL_IDLE;
    priority if (item.operation == OP_START) begin
      // a start drops any walk in flight
      nxt.va        = item.virtual_address;
      nxt.level     = LVL_4;
      res.status    = ST_REQ;
      res.address   = entry_addr(item.root_address,
                                 level_index(item.virtual_address, LVL_4), FRAME_MASK);
      res.level     = LVL_4;
    end else if (cur.level == LVL_IDLE || cur.level > LVL_4) begin
      // entry with no walk pending, defaults stand
    end else if (!present) begin
      nxt.level     = LVL_IDLE;
      res.status    = ST_FAULT;
      res.level     = cur.level;
    end else if (cur.level == LVL_3 && large_pg) begin
      nxt.level     = LVL_IDLE;
      res.status    = ST_DONE;
      res.address   = ({e_pa[PA_W-1:SHIFT_1G], {SHIFT_1G{1'b0}}} & FRAME_MASK)
                      | PA_W'(cur.va[SHIFT_1G-1:0]);
      res.page_size = SZ_1G;
      res.level     = LVL_3;
    end else if (cur.level == LVL_2 && large_pg) begin
      nxt.level     = LVL_IDLE;
      res.status    = ST_DONE;
      res.address   = ({e_pa[PA_W-1:SHIFT_2M], {SHIFT_2M{1'b0}}} & FRAME_MASK)
                      | PA_W'(cur.va[SHIFT_2M-1:0]);
      res.page_size = SZ_2M;
      res.level     = LVL_2;
    end else if (cur.level == LVL_1) begin
      nxt.level     = LVL_IDLE;
      res.status    = ST_DONE;
      res.address   = (e_pa & FRAME_MASK) | PA_W'(cur.va[SHIFT_4K-1:0]);
      res.level     = LVL_1;
    end else begin
      // large bit at level 4 is ignored, walk goes one level down
      nxt.level     = cur.level - LVL_1;
      res.status    = ST_REQ;
      res.address   = entry_addr(e_pa, level_index(cur.va, cur.level - LVL_1), FRAME_MASK);
      res.level     = cur.level - LVL_1;
    end
  end

endmodule
